// ===== hw/rtl/msit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msit_pkg;

  localparam int SLOTS_DEF   = 4;
  localparam int COUNT_W_DEF = 32;
  localparam int PRESCALE_W  = 16;
  localparam int REQ_W       = 2;
  localparam int PERIOD_W    = 32;
  localparam int SLOT_W      = 2;
  localparam int ASSIGN_W    = 3;
  localparam int COUNT_OUT_W = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_SET_PER = 2'd1,
    REQ_SET_ONE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef struct packed {
    logic load;  // capture the accepted transaction
    logic exec;  // update timer state and the result register
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msit_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msit_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output msit_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   exec;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // the result register must be free or draining before it is overwritten
  assign exec = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  assign cmd_o.load = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.exec = exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> !exec)
    else $error("exec issued twice for one transaction");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_EXEC) && !exec || (state_q == ST_EXEC))
    else $error("load did not move the controller to exec");

  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_q)
    else $error("result not presented after exec");

endmodule

`default_nettype wire

// ===== hw/rtl/msit_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msit_dp #(
  parameter int COUNT_W = msit_pkg::COUNT_W_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire msit_pkg::dp_cmd_t                  cmd_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [msit_pkg::PRESCALE_W-1:0]    cfg_prescale_i,
  input  wire logic [msit_pkg::REQ_W-1:0]         req_type_i,
  input  wire logic [msit_pkg::PERIOD_W-1:0]      period_i,
  input  wire logic [msit_pkg::SLOT_W-1:0]        slot_i,
  output logic      [msit_pkg::ASSIGN_W-1:0]      assigned_slot_o,
  output logic      [msit_pkg::SLOTS_DEF-1:0]     fired_o,
  output logic      [msit_pkg::COUNT_OUT_W-1:0]   count_value_o
);

  localparam int SLOTS = msit_pkg::SLOTS_DEF;

  // control state
  logic [msit_pkg::PRESCALE_W-1:0] prescale_q;
  logic [msit_pkg::PRESCALE_W-1:0] pcnt_q, pcnt_d;
  logic [COUNT_W-1:0]              cnt_q, cnt_d;
  logic [SLOTS-1:0]                active_q, active_d;

  // payload
  logic [COUNT_W-1:0]              match_q  [SLOTS];
  logic [COUNT_W-1:0]              match_d  [SLOTS];
  logic [COUNT_W-1:0]              reload_q [SLOTS];
  logic [COUNT_W-1:0]              reload_d [SLOTS];
  logic [SLOTS-1:0]                rel_nz_q, rel_nz_d;
  msit_pkg::req_e                  req_q;
  logic [msit_pkg::PERIOD_W-1:0]   period_q;
  logic [msit_pkg::SLOT_W-1:0]     slot_q;
  logic [msit_pkg::ASSIGN_W-1:0]   assigned_q, assigned_d;
  logic [SLOTS-1:0]                fired_q, fired_d;

  logic               expire;
  logic               found;
  logic [COUNT_W-1:0] period_cw;
  logic [COUNT_W-1:0] set_match;

  assign expire    = (pcnt_q >= prescale_q);
  assign period_cw = period_q[COUNT_W-1:0];
  assign set_match = cnt_q + period_cw - COUNT_W'(1);

  always_comb begin
    pcnt_d     = pcnt_q;
    cnt_d      = cnt_q;
    active_d   = active_q;
    rel_nz_d   = rel_nz_q;
    match_d    = match_q;
    reload_d   = reload_q;
    assigned_d = msit_pkg::ASSIGN_W'(SLOTS);
    fired_d    = '0;
    found      = 1'b0;
    unique case (req_q) inside
      msit_pkg::REQ_TICK: begin
        if (expire) begin
          pcnt_d = '0;
          for (int i = 0; i < SLOTS; i++) begin
            if (active_q[i] && match_q[i] == cnt_q) begin
              fired_d[i] = 1'b1;
              if (rel_nz_q[i]) begin
                match_d[i] = cnt_q + reload_q[i];
              end else begin
                active_d[i] = 1'b0;
              end
            end
          end
          cnt_d = cnt_q + COUNT_W'(1);
        end else begin
          pcnt_d = pcnt_q + msit_pkg::PRESCALE_W'(1);
        end
      end
      msit_pkg::REQ_SET_PER, msit_pkg::REQ_SET_ONE: begin
        // lowest free slot wins
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && !active_q[i]) begin
            found       = 1'b1;
            active_d[i] = 1'b1;
            match_d[i]  = set_match;
            assigned_d  = msit_pkg::ASSIGN_W'(i);
            if (req_q == msit_pkg::REQ_SET_PER) begin
              reload_d[i] = period_cw;
              rel_nz_d[i] = (period_q != '0);
            end else begin
              reload_d[i] = '0;
              rel_nz_d[i] = 1'b0;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (int'(slot_q) == i) begin
            active_d[i] = 1'b0;
            rel_nz_d[i] = 1'b0;
            reload_d[i] = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      pcnt_q     <= '0;
      cnt_q      <= '0;
      active_q   <= '0;
      rel_nz_q   <= '0;
    end else begin
      if (cfg_we_i) prescale_q <= cfg_prescale_i;
      if (cmd_i.exec) begin
        pcnt_q   <= pcnt_d;
        cnt_q    <= cnt_d;
        active_q <= active_d;
        rel_nz_q <= rel_nz_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= msit_pkg::req_e'(req_type_i);
      period_q <= period_i;
      slot_q   <= slot_i;
    end
    if (cmd_i.exec) begin
      match_q    <= match_d;
      reload_q   <= reload_d;
      assigned_q <= assigned_d;
      fired_q    <= fired_d;
    end
  end

  assign assigned_slot_o = assigned_q;
  assign fired_o         = fired_q;
  assign count_value_o   = msit_pkg::COUNT_OUT_W'(cnt_q);

  a_fire_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (fired_q & ~$past(active_q)) == '0)
    else $error("inactive slot fired");

  a_fire_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && req_q != msit_pkg::REQ_TICK |=> fired_q == '0)
    else $error("fire reported on a non-tick transaction");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && !(req_q == msit_pkg::REQ_TICK && expire) |=> $stable(cnt_q))
    else $error("count moved without a prescaler wrap");

endmodule

`default_nettype wire

// ===== hw/rtl/multi_slot_interval_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// multi-slot interval timer
// input channel (in_valid_i/in_ready_o) carries one request per transaction:
//   tick, set periodic, set one-shot or clear slot, with period_i and slot_i.
// output channel (out_valid_o/out_ready_i) returns one result per request:
//   assigned_slot_o (SLOTS when no slot was free or not a set request),
//   fired_o (slots that matched on this tick) and count_value_o.
// config channel (cfg_valid_i/cfg_ready_o) writes the 16-bit prescaler; it is
//   always ready and should only be written while no request is in flight.
// the request is captured in the request registers when it is taken and
//   is then executed into the output register, which raises out_valid_o.
// the controller takes a new request only while idle, after the last one
//   has updated count, prescaler divider and the slot registers.
// if the receiver stalls, the result holds in the output register and the
//   next request is taken but not executed until the result is accepted.
// reset clears the count, the prescaler, its divider and all slot flags;
//   the block is ready for requests as soon as reset is released.

module multi_slot_interval_timer #(
  parameter int COUNT_W = msit_pkg::COUNT_W_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [msit_pkg::PRESCALE_W-1:0]    cfg_prescale_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [msit_pkg::REQ_W-1:0]         req_type_i,
  input  wire logic [msit_pkg::PERIOD_W-1:0]      period_i,
  input  wire logic [msit_pkg::SLOT_W-1:0]        slot_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [msit_pkg::ASSIGN_W-1:0]      assigned_slot_o,
  output logic      [msit_pkg::SLOTS_DEF-1:0]     fired_o,
  output logic      [msit_pkg::COUNT_OUT_W-1:0]   count_value_o
);

  msit_pkg::dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  msit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  msit_dp #(
    .COUNT_W (COUNT_W)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_valid_i),
    .cfg_prescale_i  (cfg_prescale_i),
    .req_type_i      (req_type_i),
    .period_i        (period_i),
    .slot_i          (slot_i),
    .assigned_slot_o (assigned_slot_o),
    .fired_o         (fired_o),
    .count_value_o   (count_value_o)
  );

endmodule

`default_nettype wire
